FILE: hw/rtl/vsft_pkg.sv
// Shared types and constants for the video sync field tracker.
// Used by the result interface, the field machine core and the top level.
package vsft_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int LINE_CFG_W = 10;
    localparam int LINE_IDX_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LINE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BROAD_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LSYNC_MAX  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EVEN_GAP   = 3'd6;

    localparam logic [LINE_CFG_W-1:0] RST_FIRST_LINE = 10'd20;
    localparam logic [LINE_CFG_W-1:0] RST_END_LINE   = 10'd310;
    localparam logic [CFG_W-1:0]      RST_GLITCH_MAX = 16'd370;
    localparam logic [CFG_W-1:0]      RST_BROAD_MIN  = 16'd3740;
    localparam logic [CFG_W-1:0]      RST_SHORT_MAX  = 16'd440;
    localparam logic [CFG_W-1:0]      RST_LSYNC_MAX  = 16'd610;
    localparam logic [CFG_W-1:0]      RST_EVEN_GAP   = 16'd6120;

    localparam logic [2:0] BROAD_SAT  = 3'd7;
    localparam logic [2:0] BROAD_EXIT = 3'd5;
    localparam logic [7:0] SHORT_SAT  = 8'd255;
    localparam logic [7:0] SHORT_EXIT = 8'd5;
    localparam int         LINE_STEP  = 2;
    localparam int         LINE_ODD   = 1;
    localparam int         LINE_EVEN  = 2;

    localparam logic [1:0] FIELD_BROAD  = 2'd0;
    localparam logic [1:0] FIELD_LEAD   = 2'd1;
    localparam logic [1:0] FIELD_ACTIVE = 2'd2;
    localparam logic [1:0] FIELD_TRAIL  = 2'd3;

    typedef enum logic [3:0] {
        PH_BROAD = 4'b0001,
        PH_LEAD  = 4'b0010,
        PH_LINES = 4'b0100,
        PH_TRAIL = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [LINE_CFG_W-1:0] first_line;
        logic [LINE_CFG_W-1:0] end_line;
        logic [CFG_W-1:0]      glitch_max;
        logic [CFG_W-1:0]      broad_min;
        logic [CFG_W-1:0]      short_max;
        logic [CFG_W-1:0]      lsync_max;
        logic [CFG_W-1:0]      even_gap;
    } t_cfg;

    typedef struct packed {
        logic                  fire;
        logic [LINE_IDX_W-1:0] line_index;
        logic [1:0]            field_phase;
        logic                  sync_marker;
        logic                  line_marker;
    } t_result;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        code = FIELD_BROAD;
        unique case (ph)
            PH_BROAD: code = FIELD_BROAD;
            PH_LEAD:  code = FIELD_LEAD;
            PH_LINES: code = FIELD_ACTIVE;
            PH_TRAIL: code = FIELD_TRAIL;
            default:  code = FIELD_BROAD;
        endcase
        return code;
    endfunction

endpackage

FILE: hw/rtl/vsft_evt_if.sv
// Sync edge event channel: valid/ready handshake and edge payload.
// Depends on nothing but its TIME_BITS parameter.
interface vsft_evt_if #(
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] timestamp;
    logic                 sync_low;
    logic                 output_busy;

    modport source (output valid, output timestamp, output sync_low, output output_busy,
                    input ready);
    modport sink   (input valid, input timestamp, input sync_low, input output_busy,
                    output ready);
endinterface

FILE: hw/rtl/vsft_res_if.sv
// Result channel: valid/ready handshake and line fire / field status payload.
// Uses widths from vsft_pkg.
interface vsft_res_if;
    logic                            valid;
    logic                            ready;
    logic                            fire;
    logic [vsft_pkg::LINE_IDX_W-1:0] line_index;
    logic [1:0]                      field_phase;
    logic                            sync_marker;
    logic                            line_marker;

    modport source (output valid, output fire, output line_index, output field_phase,
                    output sync_marker, output line_marker, input ready);
    modport sink   (input valid, input fire, input line_index, input field_phase,
                    input sync_marker, input line_marker, output ready);
endinterface

FILE: hw/rtl/vsft_core.sv
// Field machine: pulse width measurement, glitch rejection, four-phase
// field tracking and line fire. State updates on i_step. Uses vsft_pkg.
module vsft_core #(
    parameter int TIME_BITS = 32,
    parameter int LINE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TIME_BITS-1:0] i_ts,
    input  logic                 i_sync_low,
    input  logic                 i_busy,
    input  vsft_pkg::t_cfg       i_cfg,
    output vsft_pkg::t_result    o_res
);

    localparam int LW = (LINE_BITS > vsft_pkg::LINE_CFG_W) ? LINE_BITS : vsft_pkg::LINE_CFG_W;
    localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

    vsft_pkg::t_phase     r_phase, n_phase;
    logic [TIME_BITS-1:0] r_pulse_start, n_pulse_start;
    logic                 r_pulse_done, n_pulse_done;
    logic [2:0]           r_broad_cnt, n_broad_cnt;
    logic [7:0]           r_short_cnt, n_short_cnt;
    logic [TIME_BITS-1:0] r_last_short, n_last_short;
    logic [LINE_BITS-1:0] r_line_num, n_line_num;
    logic                 r_sync_pin, n_sync_pin;
    logic                 r_line_pin, n_line_pin;

    logic [TIME_BITS-1:0] width, gap;
    logic [2:0]           broad_inc, broad_tmp;
    logic [7:0]           short_inc, short_tmp;
    logic [LINE_BITS:0]   line_sum;
    logic [LINE_BITS-1:0] line_adv;
    logic [LW-1:0]        ln_w, fl_w, el_w, diff_w;
    logic                 in_window, fire;

    assign width     = i_ts - r_pulse_start;
    assign gap       = i_ts - r_last_short;
    assign broad_inc = (r_broad_cnt < vsft_pkg::BROAD_SAT) ? r_broad_cnt + 3'd1
                                                           : vsft_pkg::BROAD_SAT;
    assign short_inc = (r_short_cnt < vsft_pkg::SHORT_SAT) ? r_short_cnt + 8'd1
                                                           : vsft_pkg::SHORT_SAT;
    assign line_sum  = {1'b0, r_line_num} + (LINE_BITS+1)'(vsft_pkg::LINE_STEP);
    assign line_adv  = (line_sum > {1'b0, LINE_TOP}) ? LINE_TOP : line_sum[LINE_BITS-1:0];
    assign ln_w      = LW'(r_line_num);
    assign fl_w      = LW'(i_cfg.first_line);
    assign el_w      = LW'(i_cfg.end_line);
    assign diff_w    = ln_w - fl_w;
    assign in_window = (ln_w >= fl_w) && (ln_w < el_w);

    always_comb begin
        n_phase       = r_phase;
        n_pulse_start = r_pulse_start;
        n_pulse_done  = r_pulse_done;
        n_broad_cnt   = r_broad_cnt;
        n_short_cnt   = r_short_cnt;
        n_last_short  = r_last_short;
        n_line_num    = r_line_num;
        n_sync_pin    = r_sync_pin;
        n_line_pin    = r_line_pin;
        broad_tmp     = r_broad_cnt;
        short_tmp     = r_short_cnt;
        fire          = 1'b0;
        if (!i_busy) begin
            if (i_sync_low) begin
                n_pulse_start = i_ts;
                n_pulse_done  = 1'b0;
                n_sync_pin    = 1'b0;
            end else if (width <= TIME_BITS'(i_cfg.glitch_max)) begin
                n_pulse_done = 1'b1;
            end else if (!r_pulse_done) begin
                n_sync_pin   = 1'b1;
                n_line_pin   = 1'b1;
                n_pulse_done = 1'b1;
                unique case (r_phase)
                    vsft_pkg::PH_BROAD: begin
                        broad_tmp = (width > TIME_BITS'(i_cfg.broad_min)) ? broad_inc : 3'd0;
                        if (broad_tmp > vsft_pkg::BROAD_EXIT) begin
                            n_phase     = vsft_pkg::PH_LEAD;
                            n_broad_cnt = 3'd0;
                        end else begin
                            n_broad_cnt = broad_tmp;
                        end
                    end
                    vsft_pkg::PH_LEAD: begin
                        if (width <= TIME_BITS'(i_cfg.short_max)) begin
                            n_short_cnt  = short_inc;
                            n_last_short = i_ts;
                        end else begin
                            n_phase     = vsft_pkg::PH_LINES;
                            n_short_cnt = 8'd0;
                            n_line_num  = (gap > TIME_BITS'(i_cfg.even_gap))
                                          ? LINE_BITS'(vsft_pkg::LINE_EVEN)
                                          : LINE_BITS'(vsft_pkg::LINE_ODD);
                        end
                    end
                    vsft_pkg::PH_LINES: begin
                        if (width > TIME_BITS'(i_cfg.lsync_max)) begin
                            if (in_window) begin
                                fire       = 1'b1;
                                n_line_pin = 1'b0;
                            end
                            n_line_num = line_adv;
                        end else begin
                            n_line_num  = '0;
                            n_short_cnt = short_inc;
                            n_phase     = vsft_pkg::PH_TRAIL;
                        end
                    end
                    vsft_pkg::PH_TRAIL: begin
                        short_tmp = (width <= TIME_BITS'(i_cfg.lsync_max)) ? short_inc : 8'd0;
                        if (short_tmp >= vsft_pkg::SHORT_EXIT) begin
                            n_phase     = vsft_pkg::PH_BROAD;
                            n_short_cnt = 8'd0;
                        end else begin
                            n_short_cnt = short_tmp;
                        end
                    end
                    default: n_phase = vsft_pkg::PH_BROAD;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= vsft_pkg::PH_BROAD;
            r_pulse_start <= '0;
            r_pulse_done  <= 1'b0;
            r_broad_cnt   <= '0;
            r_short_cnt   <= '0;
            r_last_short  <= '0;
            r_line_num    <= '0;
            r_sync_pin    <= 1'b0;
            r_line_pin    <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pulse_start <= n_pulse_start;
            r_pulse_done  <= n_pulse_done;
            r_broad_cnt   <= n_broad_cnt;
            r_short_cnt   <= n_short_cnt;
            r_last_short  <= n_last_short;
            r_line_num    <= n_line_num;
            r_sync_pin    <= n_sync_pin;
            r_line_pin    <= n_line_pin;
        end
    end

    always_comb begin
        o_res.fire        = fire;
        o_res.line_index  = fire ? diff_w[vsft_pkg::LINE_IDX_W-1:0] : '0;
        o_res.field_phase = vsft_pkg::phase_code(n_phase);
        o_res.sync_marker = n_sync_pin;
        o_res.line_marker = n_line_pin;
    end

`ifndef NO_ASSERTIONS
    a_fire_in_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && fire |=> r_phase == vsft_pkg::PH_LINES && !r_line_pin && r_pulse_done)
        else $error("fire left the line phase or line marker set");

    a_falling_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_busy && i_sync_low |=> !r_sync_pin && !r_pulse_done)
        else $error("falling edge did not open a pulse");

    a_broad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_broad_cnt <= vsft_pkg::BROAD_EXIT)
        else $error("broad count past exit threshold");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_line_num) && $stable(r_pulse_start))
        else $error("state changed without a beat");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_busy |=> $stable(r_phase) && $stable(r_sync_pin) && $stable(r_line_pin))
        else $error("busy beat changed state");
`endif

endmodule

FILE: hw/rtl/video_sync_field_tracker.sv
// Top level of the video sync field tracker: channel registers, config
// registers and the field machine. Uses vsft_pkg, vsft_evt_if, vsft_res_if, vsft_core.
//
// Takes one sync edge beat per clock and returns exactly one result beat per
// edge, which passes the input register, then the result register. The whole
// field machine update runs combinationally between those registers, so the
// sustained rate is one edge per cycle while the result stage is not stalled; a
// stalled result stage still lets one further edge be taken into the input
// register. Config writes take effect on the next cycle and belong in idle periods.
module video_sync_field_tracker #(
    parameter int TIME_BITS = 32,
    parameter int LINE_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vsft_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vsft_pkg::CFG_W-1:0]       i_cfg_wdata,
    vsft_evt_if.sink                         i_in,
    vsft_res_if.source                       o_out
);

    vsft_pkg::t_cfg       r_cfg;
    logic                 r_in_vld;
    logic [TIME_BITS-1:0] r_in_ts;
    logic                 r_in_low;
    logic                 r_in_busy;
    logic                 r_out_vld;
    vsft_pkg::t_result    r_out;
    vsft_pkg::t_result    core_res;
    logic                 advance, in_ready, step;

    assign advance  = !r_out_vld || o_out.ready;
    assign in_ready = !r_in_vld || advance;
    assign step     = r_in_vld && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_line <= vsft_pkg::RST_FIRST_LINE;
            r_cfg.end_line   <= vsft_pkg::RST_END_LINE;
            r_cfg.glitch_max <= vsft_pkg::RST_GLITCH_MAX;
            r_cfg.broad_min  <= vsft_pkg::RST_BROAD_MIN;
            r_cfg.short_max  <= vsft_pkg::RST_SHORT_MAX;
            r_cfg.lsync_max  <= vsft_pkg::RST_LSYNC_MAX;
            r_cfg.even_gap   <= vsft_pkg::RST_EVEN_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vsft_pkg::CFG_FIRST_LINE: begin
                    r_cfg.first_line <= i_cfg_wdata[vsft_pkg::LINE_CFG_W-1:0];
                end
                vsft_pkg::CFG_END_LINE: begin
                    r_cfg.end_line <= i_cfg_wdata[vsft_pkg::LINE_CFG_W-1:0];
                end
                vsft_pkg::CFG_GLITCH_MAX: r_cfg.glitch_max <= i_cfg_wdata;
                vsft_pkg::CFG_BROAD_MIN:  r_cfg.broad_min  <= i_cfg_wdata;
                vsft_pkg::CFG_SHORT_MAX:  r_cfg.short_max  <= i_cfg_wdata;
                vsft_pkg::CFG_LSYNC_MAX:  r_cfg.lsync_max  <= i_cfg_wdata;
                vsft_pkg::CFG_EVEN_GAP:   r_cfg.even_gap   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_ts   <= i_in.timestamp;
            r_in_low  <= i_in.sync_low;
            r_in_busy <= i_in.output_busy;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    vsft_core #(
        .TIME_BITS (TIME_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_ts       (r_in_ts),
        .i_sync_low (r_in_low),
        .i_busy     (r_in_busy),
        .i_cfg      (r_cfg),
        .o_res      (core_res)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_vld;
    assign o_out.fire        = r_out.fire;
    assign o_out.line_index  = r_out.line_index;
    assign o_out.field_phase = r_out.field_phase;
    assign o_out.sync_marker = r_out.sync_marker;
    assign o_out.line_marker = r_out.line_marker;

endmodule
